FILE: design/sfla_pkg.sv
// Shared types and constants for the slab free-list allocator.
// No dependencies; every other design file but sfla_ram imports this package.
package sfla_pkg;

    // Field widths fixed by the request and result formats
    localparam int ADDR_W      = 16;
    localparam int SIZE_W      = 13;
    localparam int BS_W        = 14;
    localparam int STATUS_W    = 2;
    localparam int LINK_IDX_W  = 13;
    localparam int LINK_DEPTH  = 8192;
    localparam int LINK_W      = ADDR_W + 1;

    // Default pool geometry
    localparam int DEF_SLAB_BYTES     = 4096;
    localparam int DEF_MAX_SLAB_COUNT = 16;

    // Smallest block size
    localparam logic [BS_W-1:0] MIN_BLOCK = BS_W'(8);

    // Request codes
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOM   = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic cfg_load;
        logic div_step;
        logic exec;
        logic finish;
    } sfla_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
    } sfla_stat_t;

endpackage

FILE: design/slab_free_list_allocator_top.sv
// Top level of the slab free-list allocator.
// Depends on sfla_pkg, sfla_ctrl, sfla_dp (which holds sfla_ram).
//
// Fixed-size block allocator over up to MAX_SLAB_COUNT slabs of SLAB_BYTES
// each. An allocate pops the LIFO free list, or else carves the highest
// uncarved block of the current slab, opening the next slab when it runs
// out; status 2 reports an exhausted pool. A free pushes its address
// unchecked. A request is taken only from idle, and no new one is taken
// until it has passed its finish step, where its result is loaded into
// the output register: the link store is a RAM with registered read, and a
// pop needs its read data before the next request can use the new head. A
// result waits in an output register while the next request is taken; that
// request then holds in its finish step until the waiting result is read.
// Writing the item size reopens the pool and runs a bit-serial divide for
// the block count, one quotient bit a cycle; no request is accepted while
// it runs. The link store gets no clearing pass after reset.
module slab_free_list_allocator_top import sfla_pkg::*; #(
    parameter int SLAB_BYTES     = DEF_SLAB_BYTES,
    parameter int MAX_SLAB_COUNT = DEF_MAX_SLAB_COUNT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [ADDR_W-1:0]   s_free_address,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ADDR_W-1:0]   m_block_address,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SIZE_W-1:0]   cfg_item_size_bytes
);

    sfla_cmd_t  cmd;
    sfla_stat_t stat;

    // Sequencing
    sfla_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Pool state and result
    sfla_dp #(
        .SLAB_BYTES     (SLAB_BYTES),
        .MAX_SLAB_COUNT (MAX_SLAB_COUNT)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .cfg_item_size_bytes (cfg_item_size_bytes),
        .s_func              (s_func),
        .s_free_address      (s_free_address),
        .m_status            (m_status),
        .m_block_address     (m_block_address)
    );

endmodule

FILE: design/sfla_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/sfla_ctrl.sv
// Controller state machine for the slab free-list allocator.
// Depends on sfla_pkg for the command and status structs.
module sfla_ctrl import sfla_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  sfla_stat_t stat,
    output sfla_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // Handshakes: configuration wins over a request in the same cycle
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign m_valid   = m_valid_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Commands
    always_comb begin
        cmd          = '0;
        cmd.cfg_load = cfg_valid && cfg_ready;
        cmd.exec     = s_valid && s_ready;
        cmd.div_step = (state_reg == S_DIV);
        cmd.finish   = (state_reg == S_FIN) && out_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.cfg_load) begin
                    state_next = S_DIV;
                end else if (cmd.exec) begin
                    state_next = S_FIN;
                end
            end
            S_DIV: begin
                if (stat.div_last) begin
                    state_next = S_IDLE;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the result valid until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A request and a configuration write never land together
    a_no_dual_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready && cfg_valid && cfg_ready))
        else $error("request and configuration accepted together");

    // An accepted request always moves to the finish step
    a_exec_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> (state_reg == S_FIN))
        else $error("accepted request did not reach finish");

    // A result appears only from a finish step
    a_valid_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.finish))
        else $error("result valid without finish");

endmodule

FILE: design/sfla_dp.sv
// Datapath for the slab free-list allocator: free list, carve counters,
// block-count divider and result register. Depends on sfla_pkg and sfla_ram.
module sfla_dp import sfla_pkg::*; #(
    parameter int SLAB_BYTES     = DEF_SLAB_BYTES,
    parameter int MAX_SLAB_COUNT = DEF_MAX_SLAB_COUNT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sfla_cmd_t           cmd,
    output sfla_stat_t          stat,
    input  logic [SIZE_W-1:0]   cfg_item_size_bytes,
    input  logic                s_func,
    input  logic [ADDR_W-1:0]   s_free_address,
    output logic [STATUS_W-1:0] m_status,
    output logic [ADDR_W-1:0]   m_block_address
);

    localparam int DIV_W = $clog2(SLAB_BYTES + 1);
    localparam int IDX_W = $clog2(DIV_W);
    localparam int BPS_W = $clog2(SLAB_BYTES / 8 + 1);
    localparam int CNT_W = $clog2(MAX_SLAB_COUNT + 1);

    localparam logic [DIV_W-1:0]  DIVIDEND   = DIV_W'(SLAB_BYTES);
    localparam logic [BPS_W-1:0]  RESET_BPS  = BPS_W'(SLAB_BYTES / 8);
    localparam logic [DIV_W-1:0]  RESET_FILL = DIV_W'((SLAB_BYTES / 8) * 8);
    localparam logic [ADDR_W-1:0] SLAB_STEP  = ADDR_W'(SLAB_BYTES);
    localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_SLAB_COUNT);

    // Pool state
    logic [ADDR_W-1:0]   head_reg;
    logic                nonempty_reg;
    logic [BS_W-1:0]     bs_reg;
    logic [BPS_W-1:0]    bps_reg;
    logic [BPS_W-1:0]    uncarved_reg;
    logic [DIV_W-1:0]    fill_reg;
    logic [DIV_W-1:0]    carve_off_reg;
    logic [ADDR_W-1:0]   slab_base_reg;
    logic [CNT_W-1:0]    slabs_reg;

    // Divider state
    logic [BS_W:0]       div_rem_reg;
    logic [DIV_W-1:0]    div_quo_reg;
    logic [IDX_W-1:0]    div_idx_reg;

    // Pending request
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_pop_reg;
    logic                res_carve_reg;

    // Output register
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]   out_addr_reg;

    logic [LINK_W-1:0]   rd_data;
    logic                ram_we;
    logic                ram_re;

    // Block size from the written item size
    logic [BS_W-1:0]     sz_min;
    logic [BS_W-1:0]     sz_rnd;
    logic [BS_W-1:0]     bs_new;

    always_comb begin
        sz_min = {1'b0, cfg_item_size_bytes};
        if (sz_min < MIN_BLOCK) begin
            sz_min = MIN_BLOCK;
        end
        sz_rnd = sz_min + BS_W'(7);
        bs_new = {sz_rnd[BS_W-1:3], 3'b000};
    end

    // One restoring divide step per cycle
    logic [BS_W:0]       div_trial;
    logic                div_bit;
    logic [BS_W:0]       div_rem_new;
    logic [DIV_W-1:0]    div_quo_new;

    always_comb begin
        div_trial   = {div_rem_reg[BS_W-1:0], DIVIDEND[div_idx_reg]};
        div_bit     = (div_trial >= {1'b0, bs_reg});
        div_rem_new = div_bit ? (div_trial - {1'b0, bs_reg}) : div_trial;
        div_quo_new = {div_quo_reg[DIV_W-2:0], div_bit};
    end

    assign stat.div_last = (div_idx_reg == '0);

    // Carve decision for an allocate with an empty free list
    logic                slab_empty;
    logic                oom;
    logic [DIV_W-1:0]    carve_from;
    logic [DIV_W-1:0]    carve_off_new;
    logic [BPS_W-1:0]    uncarved_new;

    always_comb begin
        slab_empty    = (uncarved_reg == '0);
        oom           = slab_empty && ((bps_reg == '0) || (slabs_reg >= MAX_CNT));
        carve_from    = slab_empty ? fill_reg : carve_off_reg;
        carve_off_new = carve_from - DIV_W'(bs_reg);
        uncarved_new  = (slab_empty ? bps_reg : uncarved_reg) - BPS_W'(1);
    end

    // Link store: push writes on free, pop reads on allocate
    assign ram_we = cmd.exec && (s_func == FN_FREE);
    assign ram_re = cmd.exec && (s_func == FN_ALLOC) && nonempty_reg;

    sfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s_free_address[ADDR_W-1:3]),
        .wr_data ({nonempty_reg, head_reg}),
        .rd_en   (ram_re),
        .rd_addr (head_reg[ADDR_W-1:3]),
        .rd_data (rd_data)
    );

    // Control part of the pool state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            nonempty_reg  <= 1'b0;
            bs_reg        <= MIN_BLOCK;
            bps_reg       <= RESET_BPS;
            uncarved_reg  <= RESET_BPS;
            fill_reg      <= RESET_FILL;
            carve_off_reg <= RESET_FILL;
            slab_base_reg <= '0;
            slabs_reg     <= CNT_W'(1);
            div_idx_reg   <= '0;
        end else if (cmd.cfg_load) begin
            // Reopen the pool and start the block-count divide
            head_reg      <= '0;
            nonempty_reg  <= 1'b0;
            bs_reg        <= bs_new;
            slab_base_reg <= '0;
            slabs_reg     <= CNT_W'(1);
            div_idx_reg   <= IDX_W'(DIV_W - 1);
        end else if (cmd.div_step) begin
            div_idx_reg <= div_idx_reg - IDX_W'(1);
            if (stat.div_last) begin
                bps_reg       <= BPS_W'(div_quo_new);
                uncarved_reg  <= BPS_W'(div_quo_new);
                fill_reg      <= DIVIDEND - DIV_W'(div_rem_new);
                carve_off_reg <= DIVIDEND - DIV_W'(div_rem_new);
            end
        end else if (cmd.exec) begin
            if (s_func == FN_FREE) begin
                head_reg     <= s_free_address;
                nonempty_reg <= 1'b1;
            end else if (!nonempty_reg && !oom) begin
                uncarved_reg  <= uncarved_new;
                carve_off_reg <= carve_off_new;
                if (slab_empty) begin
                    slabs_reg     <= slabs_reg + CNT_W'(1);
                    slab_base_reg <= slab_base_reg + SLAB_STEP;
                end
            end
        end else if (cmd.finish && res_pop_reg) begin
            // Advance the head to the popped link
            head_reg     <= rd_data[ADDR_W-1:0];
            nonempty_reg <= rd_data[LINK_W-1];
        end
    end

    // Divider working registers
    always_ff @(posedge aclk) begin
        if (cmd.cfg_load) begin
            div_rem_reg <= '0;
            div_quo_reg <= '0;
        end else if (cmd.div_step) begin
            div_rem_reg <= div_rem_new;
            div_quo_reg <= div_quo_new;
        end
    end

    // Record what the pending request resolved to
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_pop_reg   <= (s_func == FN_ALLOC) && nonempty_reg;
            res_carve_reg <= (s_func == FN_ALLOC) && !nonempty_reg && !oom;
            if (s_func == FN_FREE) begin
                res_status_reg <= ST_FREE;
            end else if (nonempty_reg || !oom) begin
                res_status_reg <= ST_ALLOC;
            end else begin
                res_status_reg <= ST_OOM;
            end
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_status_reg <= res_status_reg;
            if (res_pop_reg) begin
                out_addr_reg <= head_reg;
            end else if (res_carve_reg) begin
                out_addr_reg <= slab_base_reg + ADDR_W'(carve_off_reg);
            end else begin
                out_addr_reg <= '0;
            end
        end
    end

    assign m_status        = out_status_reg;
    assign m_block_address = out_addr_reg;

    // The slab count stays within the pool
    a_slabs_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (slabs_reg != '0) && (slabs_reg <= MAX_CNT))
        else $error("slab count out of range");

    // Carving never leaves more blocks than a slab holds
    a_uncarved_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> (uncarved_reg <= bps_reg))
        else $error("uncarved count exceeds blocks per slab");

    // A slab never holds more blocks than the smallest block size allows
    a_bps_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        bps_reg <= RESET_BPS)
        else $error("blocks per slab above the minimum-size count");

endmodule

FILE: tb/sv/slab_free_list_allocator_top_test.sv
// Self-checking testbench for slab_free_list_allocator_top: directed and random
// allocate/free traffic over several item sizes, checked against a shadow pool.
// Depends on sfla_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module slab_free_list_allocator_top_test;
    import sfla_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } pool_outcome_t;

    logic                aclk;
    logic                aresetn             = 1'b0;
    logic                s_valid             = 1'b0;
    logic                s_ready;
    logic                s_func              = FN_ALLOC;
    logic [ADDR_W-1:0]   s_free_address      = '0;
    logic                m_valid;
    logic                m_ready             = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [ADDR_W-1:0]   m_block_address;
    logic                cfg_valid           = 1'b0;
    logic                cfg_ready;
    logic [SIZE_W-1:0]   cfg_item_size_bytes = SIZE_W'(8);

    // Shadow pool state
    int unsigned         blk_bytes;
    int unsigned         per_slab;
    int unsigned         slabs_open;
    int unsigned         uncarved;
    logic [ADDR_W-1:0]   head;
    logic                head_valid;
    logic [LINK_W-1:0]   link_shadow [LINK_DEPTH];

    pool_outcome_t       outcome_q [$];
    logic [ADDR_W-1:0]   live_blocks [$];

    bit                  idling     = 1'b1;
    int                  mismatches = 0;
    int                  checked    = 0;
    int                  n_alloc    = 0;
    int                  n_free     = 0;
    int                  n_oom      = 0;
    int                  n_cfg      = 0;

    slab_free_list_allocator_top u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_func              (s_func),
        .s_free_address      (s_free_address),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_block_address     (m_block_address),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_item_size_bytes (cfg_item_size_bytes)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAIL slab_free_list_allocator_top");
        $finish;
    end

    // Reopen the shadow pool for a new item size
    function automatic void reopen_pool(logic [SIZE_W-1:0] size);
        blk_bytes  = (size < 8) ? 8 : size;
        blk_bytes  = (blk_bytes + 7) / 8 * 8;
        per_slab   = DEF_SLAB_BYTES / blk_bytes;
        head       = '0;
        head_valid = 1'b0;
        slabs_open = 1;
        uncarved   = per_slab;
        live_blocks.delete();
    endfunction

    // Advance the shadow pool by one request and return its outcome
    function automatic pool_outcome_t pool_outcome(logic fn, logic [ADDR_W-1:0] a);
        pool_outcome_t     r;
        logic [LINK_W-1:0] lk;
        int unsigned       full;
        r.status = ST_ALLOC;
        r.addr   = '0;
        if (fn == FN_FREE) begin
            link_shadow[a[ADDR_W-1:3]] = {head_valid, head};
            head       = a;
            head_valid = 1'b1;
            r.status   = ST_FREE;
        end else if (head_valid) begin
            lk         = link_shadow[head[ADDR_W-1:3]];
            r.addr     = head;
            head       = lk[ADDR_W-1:0];
            head_valid = lk[ADDR_W];
        end else begin
            // open the next slab when the current one is carved out
            if (uncarved == 0 && per_slab != 0 && slabs_open < DEF_MAX_SLAB_COUNT) begin
                slabs_open++;
                uncarved = per_slab;
            end
            if (uncarved == 0) begin
                r.status = ST_OOM;
            end else begin
                uncarved--;
                full   = (slabs_open - 1) * DEF_SLAB_BYTES + uncarved * blk_bytes;
                r.addr = ADDR_W'(full);
            end
        end
        return r;
    endfunction

    function automatic int draw_wait();
        return idling ? $urandom_range(0, 13) : 0;
    endfunction

    // Send one request and record what it should produce
    task automatic send_request(input logic fn, input logic [ADDR_W-1:0] a,
                                output pool_outcome_t res);
        int gap;
        gap = draw_wait();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= fn;
        s_free_address <= a;
        do @(posedge aclk); while (!s_ready);
        res = pool_outcome(fn, a);
        outcome_q.push_back(res);
        if (fn == FN_ALLOC && res.status == ST_ALLOC)
            live_blocks.push_back(res.addr);
    endtask

    task automatic alloc_block();
        pool_outcome_t res;
        send_request(FN_ALLOC, ADDR_W'($urandom), res);
    endtask

    task automatic free_block(input logic [ADDR_W-1:0] a);
        pool_outcome_t res;
        send_request(FN_FREE, a, res);
    endtask

    // Drop valid and hold until every outstanding result is back
    task automatic hold_requests();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_item_size(input logic [SIZE_W-1:0] size);
        hold_requests();
        @(negedge aclk);
        cfg_valid           <= 1'b1;
        cfg_item_size_bytes <= size;
        do @(posedge aclk); while (!cfg_ready);
        reopen_pool(size);
        n_cfg++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, then take one result
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic void flag_field(string name, int exp_v, int got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
                     $realtime, name, exp_v, exp_v, got_v, got_v);
    endfunction

    // Compare each accepted result against the oldest expectation
    always @(posedge aclk) begin
        pool_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                flag_field("unexpected result, status", -1, m_status);
            end else begin
                want = outcome_q.pop_front();
                checked++;
                if (m_status !== want.status)
                    flag_field("status", want.status, m_status);
                if (m_block_address !== want.addr)
                    flag_field("block_address", want.addr, m_block_address);
                case (want.status)
                    ST_ALLOC: n_alloc++;
                    ST_FREE:  n_free++;
                    default:  n_oom++;
                endcase
            end
        end
    end

    // Reset pool: carve downwards, LIFO reuse, odd free addresses
    task automatic test_default_pool();
        idling = 1'b1;
        alloc_block();
        alloc_block();
        free_block(ADDR_W'(4088));
        alloc_block();
        free_block('0);
        free_block('1);
        alloc_block();
        alloc_block();
    endtask

    // One block per slab: run all slabs dry, then report out of memory
    task automatic test_exhaustion();
        idling = 1'b0;
        write_item_size(SIZE_W'(4096));
        repeat (DEF_MAX_SLAB_COUNT + 1) alloc_block();
    endtask

    // Block larger than a slab: nothing can be carved
    task automatic test_oversize();
        idling = 1'b1;
        write_item_size(SIZE_W'(4097));
        alloc_block();
    endtask

    // Mostly well-formed alloc/free traffic with some stray frees
    task automatic run_mix(input logic [SIZE_W-1:0] size, input int count,
                           input int free_pct, input bit idle);
        int                pick;
        int                k;
        logic [ADDR_W-1:0] a;
        idling = idle;
        write_item_size(size);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 2)
                hold_requests();
            pick = $urandom_range(0, 99);
            if (pick < free_pct && live_blocks.size() > 0) begin
                k = $urandom_range(0, live_blocks.size() - 1);
                a = live_blocks[k];
                live_blocks.delete(k);
                free_block(a);
            end else if (pick < free_pct + 8) begin
                // stray frees: random, double, or misaligned
                a = ADDR_W'($urandom);
                if (live_blocks.size() > 0) begin
                    k = $urandom_range(0, live_blocks.size() - 1);
                    case ($urandom_range(0, 2))
                        0: ;
                        1: a = live_blocks[k];
                        default: a = live_blocks[k] + ADDR_W'($urandom_range(1, 7));
                    endcase
                end
                free_block(a);
            end else begin
                alloc_block();
            end
        end
    endtask

    task automatic test_random_mix();
        run_mix(SIZE_W'(8), 70, 40, 1'b1);
        run_mix(SIZE_W'(1), 50, 45, 1'b0);
        run_mix(SIZE_W'(2048), 70, 25, 1'b1);
        run_mix(SIZE_W'(4096), 40, 30, 1'b1);
        run_mix(SIZE_W'($urandom_range(1, 4096)), 60, 40, 1'b1);
        run_mix(SIZE_W'(8191), 20, 50, 1'b1);
        run_mix(SIZE_W'(0), 40, 40, 1'b0);
        run_mix(SIZE_W'(3000), 40, 30, 1'b1);
        run_mix(SIZE_W'($urandom_range(100, 600)), 50, 35, 1'b1);
    endtask

    initial begin
        foreach (link_shadow[i]) link_shadow[i] = '0;
        reopen_pool(SIZE_W'(8));
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_pool();
        test_exhaustion();
        test_oversize();
        test_random_mix();

        // drain, then give stray results time to show up
        hold_requests();
        idling = 1'b0;
        repeat (10) @(posedge aclk);

        $display("Checked %0d results over %0d item-size writes:", checked, n_cfg);
        $display("  %0d allocations, %0d frees, %0d out-of-memory; %0d mismatches",
                 n_alloc, n_free, n_oom, mismatches);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("PASS slab_free_list_allocator_top");
        end else begin
            $display("FAIL slab_free_list_allocator_top");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/sfla_pkg.sv
design/sfla_ram.sv
design/sfla_ctrl.sv
design/sfla_dp.sv
design/slab_free_list_allocator_top.sv
tb/sv/slab_free_list_allocator_top_test.sv
